[hdl/lmb_pkg.sv]
`default_nettype none
package lmb_pkg;

	localparam int MAX_DIM    = 1024;
	localparam int PIXEL_BITS = 8;
	localparam int CFG_W      = 11;
	localparam int PIX_IN_W   = 8;

	localparam int COL_W     = $clog2(MAX_DIM);
	localparam int ROW_W     = $clog2(MAX_DIM + 2);
	localparam int SLOT_W    = 2;
	localparam int SLOTS     = 4;
	localparam int MEM_DEPTH = SLOTS * MAX_DIM;
	localparam int SUM_W     = PIXEL_BITS + 4;
	localparam int DIM_RESET = (MAX_DIM < 1024) ? MAX_DIM : 1024;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	// one image column of the window: rows above, centre and below
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	typedef enum logic [1:0] {
		COL_FIRST,
		COL_SECOND,
		COL_OTHER
	} col_kind_t;

	typedef struct packed {
		col_t      column;
		logic      emit;
		col_kind_t kind;
		logic      frame_end;
	} step_t;

endpackage
`default_nettype wire

[hdl/lmb_channels.sv]
`default_nettype none
interface lmb_req_if import lmb_pkg::*;;
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [PIX_IN_W-1:0] pixel;

	modport source (output valid, req_type, pixel, input ready);
	modport sink (input valid, req_type, pixel, output ready);
endinterface

interface lmb_res_if;
	logic valid;
	logic ready;
	logic above_mean;
	logic frame_end;

	modport source (output valid, above_mean, frame_end, input ready);
	modport sink (input valid, above_mean, frame_end, output ready);
endinterface

interface lmb_cfg_if import lmb_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] image_dim;

	modport source (output valid, image_dim, input ready);
	modport sink (input valid, image_dim, output ready);
endinterface
`default_nettype wire

[hdl/lmb_front.sv]
`default_nettype none
module lmb_front import lmb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	lmb_req_if.sink               req,
	lmb_cfg_if.sink               cfg,
	input  wire logic [LVL_W-1:0] fifo_level,
	output logic                  push,
	output step_t                 push_data
);

	function automatic logic [ROW_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		if (v < CFG_W'(2)) begin
			return ROW_W'(2);
		end else if (32'(v) > MAX_DIM) begin
			return ROW_W'(MAX_DIM);
		end else begin
			return ROW_W'(v);
		end
	endfunction

	logic [ROW_W-1:0] dim_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic             complete;
	logic             last_col;
	logic             final_step;
	logic             is_drain;
	logic             acc;
	logic             step;
	logic             wr;
	logic             emit;
	col_kind_t        kind;
	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] mid_slot;
	logic [SLOT_W-1:0] top_slot;

	pix_t      mem [MEM_DEPTH];
	pix_t      top_s1;
	pix_t      mid_s1;
	pix_t      pixel_s1;
	logic      valid_s1;
	logic      emit_s1;
	logic      bot_rep_s1;
	logic      end_s1;
	col_kind_t kind_s1;

	assign cfg.ready  = 1'b1;
	assign req.ready  = ({1'b0, fifo_level} + (LVL_W+1)'(valid_s1)) < (LVL_W+1)'(FIFO_DEPTH);

	assign complete   = row_q >= dim_q;
	assign last_col   = ROW_W'(col_q) == (dim_q - ROW_W'(1));
	assign final_step = row_q == (dim_q + ROW_W'(1));
	assign is_drain   = req.req_type == REQ_DRAIN;
	assign acc        = req.valid && req.ready;
	// early drain ticks do nothing; once the frame is in, every item drains
	assign step       = acc && (complete || !is_drain);
	assign wr         = acc && !complete && !is_drain;
	assign emit       = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));

	always_comb begin
		if (col_q == '0) begin
			kind = COL_FIRST;
		end else if (col_q == COL_W'(1)) begin
			kind = COL_SECOND;
		end else begin
			kind = COL_OTHER;
		end
	end

	// rows r-1 and r-2 sit in the slots behind the one being written; top row clamps
	assign wr_slot  = row_q[SLOT_W-1:0];
	assign mid_slot = wr_slot - SLOT_W'(1);
	assign top_slot = (row_q == ROW_W'(1)) ? mid_slot : wr_slot - SLOT_W'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q    <= ROW_W'(DIM_RESET);
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= step;
			if (cfg.valid && cfg.ready) begin
				dim_q <= clamp_dim(cfg.image_dim);
				row_q <= '0;
				col_q <= '0;
			end else if (step) begin
				if (final_step) begin
					row_q <= '0;
					col_q <= '0;
				end else if (last_col) begin
					row_q <= row_q + ROW_W'(1);
					col_q <= '0;
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[{wr_slot, col_q}] <= pix_t'(req.pixel);
		end
		top_s1 <= mem[{top_slot, col_q}];
		mid_s1 <= mem[{mid_slot, col_q}];
	end

	always_ff @(posedge clk) begin
		pixel_s1   <= pix_t'(req.pixel);
		emit_s1    <= emit;
		bot_rep_s1 <= complete;
		end_s1     <= final_step;
		kind_s1    <= kind;
	end

	assign push                 = valid_s1;
	assign push_data.column.top = top_s1;
	assign push_data.column.mid = mid_s1;
	assign push_data.column.bot = bot_rep_s1 ? mid_s1 : pixel_s1;
	assign push_data.emit       = emit_s1;
	assign push_data.kind       = kind_s1;
	assign push_data.frame_end  = end_s1;

`ifndef NO_ASSERTIONS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (32'(fifo_level) < FIFO_DEPTH))
		else $error("step pushed into a full queue");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= (dim_q + ROW_W'(1)))
		else $error("row counter ran past the drain row");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(step && final_step && !(cfg.valid && cfg.ready)) |=> (row_q == '0 && col_q == '0))
		else $error("counters did not restart after the last result");
`endif

endmodule
`default_nettype wire

[hdl/lmb_fifo.sv]
`default_nettype none
module lmb_fifo import lmb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire step_t       push_data,
	input  wire logic        pop,
	output logic             pop_valid,
	output step_t            pop_data,
	output logic [LVL_W-1:0] level
);

	step_t              slots [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [LVL_W-1:0]   level_q;

	assign level     = level_q;
	assign pop_valid = level_q != '0;
	assign pop_data  = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> level_q != '0)
		else $error("pop from empty queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (32'(level_q) < FIFO_DEPTH))
		else $error("push into full queue");
`endif

endmodule
`default_nettype wire

[hdl/lmb_back.sv]
`default_nettype none
module lmb_back import lmb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pop_valid,
	input  wire step_t pop_data,
	output logic       pop,
	lmb_res_if.source  res
);

	col_t             a_q;
	col_t             b_q;
	col_t             left_c;
	col_t             centre_c;
	col_t             right_c;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] centre9;
	logic             bit_c;
	logic             out_valid_q;
	logic             above_q;
	logic             end_q;

	// a step that yields nothing never waits on the output side
	assign pop = pop_valid && (!pop_data.emit || !out_valid_q || res.ready);

	// a_q holds column c-1, b_q column c-2 relative to the incoming column
	always_comb begin
		case (pop_data.kind)
			COL_FIRST: begin
				left_c   = b_q;
				centre_c = a_q;
				right_c  = a_q;
			end
			COL_SECOND: begin
				left_c   = a_q;
				centre_c = a_q;
				right_c  = pop_data.column;
			end
			default: begin
				left_c   = b_q;
				centre_c = a_q;
				right_c  = pop_data.column;
			end
		endcase
	end

	assign sum = SUM_W'(left_c.top) + SUM_W'(left_c.mid) + SUM_W'(left_c.bot)
		+ SUM_W'(centre_c.top) + SUM_W'(centre_c.mid) + SUM_W'(centre_c.bot)
		+ SUM_W'(right_c.top) + SUM_W'(right_c.mid) + SUM_W'(right_c.bot);
	assign centre9 = (SUM_W'(centre_c.mid) << 3) + SUM_W'(centre_c.mid);
	assign bit_c   = centre9 > sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (pop && pop_data.emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			b_q <= a_q;
			a_q <= pop_data.column;
		end
		if (pop && pop_data.emit) begin
			above_q <= bit_c;
			end_q   <= pop_data.frame_end;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.above_mean = above_q;
	assign res.frame_end  = end_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_data.emit) |-> (!out_valid_q || res.ready))
		else $error("held result overwritten");
`endif

endmodule
`default_nettype wire

[hdl/local_mean_binarize_3x3_top.sv]
// Streaming 3x3 local-mean binarizer for a square image, edge-replicated borders.
// req: one beat per item; req_type 0 carries a pixel in raster order, 1 is a
//   drain tick. Drain ticks before the frame's last pixel are dropped; after
//   it, every beat (pixel or tick) flushes one pending result.
// res: one beat per pixel, raster order: above_mean = 9*centre > 3x3 sum,
//   frame_end marks the image's final pixel.
// cfg: one beat writes image_dim (clamped to 2..1024) and restarts the frame;
//   write only while the block is idle.
// Throughput: one item per clock while the queue has room; a stalled res
//   can hold req. Results trail pixels by image_dim+1 items, so image_dim+1
//   drain beats finish a frame.
// Latency is set by the registered line-buffer read, the queue slot and the
//   output register; a 4-entry queue between them lets the input keep flowing
//   while res stalls, and req drops ready once the queue plus the read stage
//   hold four steps.
// Reset: image_dim is 1024, counters at the frame start, no result pending.
//   The line buffers are not cleared; every window read is of a pixel already
//   written in the current frame.
`default_nettype none
module local_mean_binarize_3x3_top import lmb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	lmb_req_if.sink   req,
	lmb_res_if.source res,
	lmb_cfg_if.sink   cfg
);

	logic             push;
	step_t            push_data;
	logic             pop;
	logic             pop_valid;
	step_t            pop_data;
	logic [LVL_W-1:0] fifo_level;

	lmb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.fifo_level (fifo_level),
		.push       (push),
		.push_data  (push_data)
	);

	lmb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.level     (fifo_level)
	);

	lmb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.res       (res)
	);

endmodule
`default_nettype wire
